@@ rtl/stable_priority_queue_assert.svh @@
// Assertion helpers for the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int IN_PRI_BITS = 8;
   localparam int OCC_BITS    = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic insert;
      logic pop;
   } ctrl_type;

endpackage

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIORITY_BITS = 8
) (
   input  logic                     clock,
   input  ctrl_type                 ctrl,
   input  logic                     in_use,
   input  logic                     ge_left,
   input  logic [VALUE_BITS-1:0]    new_value,
   input  logic [PRIORITY_BITS-1:0] new_priority,
   input  logic [VALUE_BITS-1:0]    left_value,
   input  logic [PRIORITY_BITS-1:0] left_priority,
   input  logic [VALUE_BITS-1:0]    right_value,
   input  logic [PRIORITY_BITS-1:0] right_priority,
   output logic                     ge_self,
   output logic [VALUE_BITS-1:0]    cell_value,
   output logic [PRIORITY_BITS-1:0] cell_priority
);

   logic [VALUE_BITS-1:0]    value_ff, value_in;
   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;

   // entries ahead of a newcomer: equal priorities stay in front
   assign ge_self = in_use && (priority_ff >= new_priority);

   always_comb begin
      value_in    = value_ff;
      priority_in = priority_ff;
      if (ctrl.insert && !ge_self) begin
         if (ge_left) begin
            value_in    = new_value;
            priority_in = new_priority;
         end else begin
            value_in    = left_value;
            priority_in = left_priority;
         end
      end else if (ctrl.pop) begin
         value_in    = right_value;
         priority_in = right_priority;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   assign cell_value    = value_ff;
   assign cell_priority = priority_ff;

endmodule

@@ rtl/stable_priority_queue.sv @@
`timescale 1ns / 1ps
// Stable priority queue of up to CAPACITY entries.
// Request channel (req_valid/req_ready): opcode, item_value, item_priority.
//   Insert places the entry behind all entries of greater or equal
//   priority; pop removes the head; clear empties the queue.
// Response channel (rsp_valid/rsp_ready): one transaction per request with
//   popped_value, pop_valid, status and occupancy after the operation.
// Storage is a row of cells, each holding one entry; every cell compares
//   its priority with the incoming one at once and loads from itself, its
//   left neighbor, the new entry or its right neighbor.
// The response is registered and shows in the cycle after the
//   request transaction.
// Throughput: one request per cycle unless a stalled response holds it off.
// The request side is taken while the response register is empty or is
//   being drained in the same cycle; a stalled response holds requests off.
// Reset empties the queue and the response register; cell contents are
//   not cleared and are never read before being written.
`include "stable_priority_queue_assert.svh"

module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   input  logic signed [31:0]     req_item_value,
   input  logic [IN_PRI_BITS-1:0] req_item_priority,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_popped_value,
   output logic                   rsp_pop_valid,
   output logic [1:0]             rsp_status,
   output logic [OCC_BITS-1:0]    rsp_occupancy
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]            count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    popped_ff, popped_in;
   logic                     pop_valid_ff, pop_valid_in;
   logic [1:0]               status_ff, status_in;
   logic [CW-1:0]            occ_ff;

   logic                     accept;
   logic                     full;
   logic                     empty;
   ctrl_type                 ctrl;
   logic [PRIORITY_BITS-1:0] new_priority;

   logic [VALUE_BITS-1:0]    values     [CAPACITY];
   logic [PRIORITY_BITS-1:0] priorities [CAPACITY];
   logic [CAPACITY-1:0]      ge;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   generate
      if (PRIORITY_BITS >= IN_PRI_BITS) begin : g_pri_wide
         assign new_priority = PRIORITY_BITS'(req_item_priority);
      end else begin : g_pri_narrow
         assign new_priority = req_item_priority[PRIORITY_BITS-1:0];
      end
   endgenerate

   always_comb begin
      ctrl.insert  = accept && (req_opcode == OP_INSERT) && !full;
      ctrl.pop     = accept && (req_opcode == OP_POP) && !empty;
      count_in     = count_ff;
      popped_in    = '0;
      pop_valid_in = 1'b0;
      status_in    = ST_OK;
      case (req_opcode)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in     = count_ff - 1'b1;
               popped_in    = values[0];
               pop_valid_in = 1'b1;
            end
         end
         OP_CLEAR: count_in = '0;
         default: count_in = count_ff;
      endcase
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic                     ge_left;
         logic [VALUE_BITS-1:0]    left_value, right_value;
         logic [PRIORITY_BITS-1:0] left_priority, right_priority;

         if (i == 0) begin : g_head
            assign ge_left       = 1'b1;
            assign left_value    = req_item_value;
            assign left_priority = new_priority;
         end else begin : g_body
            assign ge_left       = ge[i-1];
            assign left_value    = values[i-1];
            assign left_priority = priorities[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign right_value    = '0;
            assign right_priority = '0;
         end else begin : g_inner
            assign right_value    = values[i+1];
            assign right_priority = priorities[i+1];
         end

         spq_cell #(
            .PRIORITY_BITS(PRIORITY_BITS)
         ) u_cell (
            .clock         (clock),
            .ctrl          (ctrl),
            .in_use        (count_ff > CW'(i)),
            .ge_left       (ge_left),
            .new_value     (req_item_value),
            .new_priority  (new_priority),
            .left_value    (left_value),
            .left_priority (left_priority),
            .right_value   (right_value),
            .right_priority(right_priority),
            .ge_self       (ge[i]),
            .cell_value    (values[i]),
            .cell_priority (priorities[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff    <= popped_in;
         pop_valid_ff <= pop_valid_in;
         status_ff    <= status_in;
         occ_ff       <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_pop_valid    = pop_valid_ff;
   assign rsp_status       = status_ff;

   generate
      if (CW >= OCC_BITS) begin : g_occ_trunc
         assign rsp_occupancy = occ_ff[OCC_BITS-1:0];
      end else begin : g_occ_ext
         assign rsp_occupancy = OCC_BITS'(occ_ff);
      end
   endgenerate

   `SPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count over capacity")
   `SPQ_ASSERT_NEXT(a_insert_full, clock, reset, accept && req_opcode == OP_INSERT && full, rsp_status == ST_FULL && count_ff == CW'(CAPACITY), "full insert not refused")
   `SPQ_ASSERT_NEXT(a_pop_count, clock, reset, accept && req_opcode == OP_POP && !empty, rsp_pop_valid && count_ff == $past(count_ff) - 1'b1, "pop did not remove an entry")
   `SPQ_ASSERT_SAME(a_pop_status, clock, reset, rsp_valid && rsp_pop_valid, rsp_status == ST_OK, "pop result with error status")

endmodule
